### hw/rtl/thermal_talus_erosion_assert.svh
`ifndef THERMAL_TALUS_EROSION_ASSERT_SVH
`define THERMAL_TALUS_EROSION_ASSERT_SVH

// Checks sampled on clk_i, held off while rst_ni is low.
`define TTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition pre in one cycle implies post in the next.
`define TTE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### hw/rtl/tte_pkg.sv
package tte_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RUN   = 2'd2
  } op_e;

  localparam logic [1:0] CFG_GRID_SIZE  = 2'd0;
  localparam logic [1:0] CFG_TALUS      = 2'd1;
  localparam logic [1:0] CFG_SLUMP_RATE = 2'd2;
  localparam logic [1:0] CFG_PASS_COUNT = 2'd3;

  localparam int CFG_DATA_W = 15;

  localparam logic [6:0]  GRID_SIZE_RST = 7'd64;
  localparam logic [14:0] TALUS_RST     = 15'd256;
  localparam logic [8:0]  RATE_RST      = 9'd128;
  localparam logic [7:0]  PASS_RST      = 8'd1;
  localparam logic [8:0]  RATE_ONE      = 9'd256;

  // rate product is shifted by 9: Q1.8 rate times one half
  localparam int MOVE_SHIFT = 9;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_SCAN,
    ST_DROP,
    ST_TALUS,
    ST_MUL,
    ST_DHERE,
    ST_DLOW_RD,
    ST_DLOW_WR,
    ST_APPLY_RD,
    ST_APPLY_WR,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    ALU_PASS_IN,
    ALU_PASS_RD,
    ALU_CMP,
    ALU_DROP,
    ALU_TALUS,
    ALU_DSUB,
    ALU_DADD,
    ALU_APPLY
  } alu_sel_e;

  typedef enum logic [1:0] {
    DIR_XP,
    DIR_XN,
    DIR_ZP,
    DIR_ZN
  } dir_e;

  typedef struct packed {
    logic       in_ready;
    logic       host;
    logic       h_rd;
    logic       h_wr;
    logic       d_rd;
    logic       d_wr;
    logic       d_zero;
    alu_sel_e   alu_sel;
    logic       ld_here;
    logic       ld_nb;
    logic       ld_drop;
    logic       ld_excess;
    logic       ld_prod;
    logic       out_ld;
    logic [1:0] out_op;
  } ctrl_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] op;
    logic       out_free;
    logic       nb_lower;
    logic       excess_pos;
  } stat_t;

endpackage

### hw/rtl/tte_in_if.sv
interface tte_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [5:0]         column;
  logic [5:0]         row;
  logic signed [15:0] write_height;

  modport source (output valid, output operation, output column, output row,
                  output write_height, input ready);
  modport sink (input valid, input operation, input column, input row,
                input write_height, output ready);
endinterface

### hw/rtl/tte_out_if.sv
interface tte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] read_height;
  logic [1:0]         done_operation;

  modport source (output valid, output read_height, output done_operation, input ready);
  modport sink (input valid, input read_height, input done_operation, output ready);
endinterface

### hw/rtl/tte_alu.sv
module tte_alu #(
  parameter int HEIGHT_BITS = 16,
  parameter int AW          = 20
) (
  input  logic [AW-1:0]          a_i,
  input  logic [AW-1:0]          b_i,
  input  logic                   sub_i,
  output logic [AW-1:0]          sum_o,
  output logic                   neg_o,
  output logic [HEIGHT_BITS-1:0] sat_h_o,
  output logic [15:0]            sat16_o
);

  localparam int HB = HEIGHT_BITS;

  logic ovf_h;
  logic ovf_16;

  assign sum_o = sub_i ? (a_i - b_i) : (a_i + b_i);
  assign neg_o = sum_o[AW-1];

  // out of range when the upper bits are not a pure sign extension
  assign ovf_h  = (|sum_o[AW-1:HB-1]) && !(&sum_o[AW-1:HB-1]);
  assign ovf_16 = (|sum_o[AW-1:15]) && !(&sum_o[AW-1:15]);

  assign sat_h_o = ovf_h ? {sum_o[AW-1], {(HB-1){~sum_o[AW-1]}}} : sum_o[HB-1:0];
  assign sat16_o = ovf_16 ? {sum_o[AW-1], {15{~sum_o[AW-1]}}} : sum_o[15:0];

endmodule

### hw/rtl/tte_seq.sv
module tte_seq #(
  parameter int GRID_MAX = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [6:0]                        grid_size_i,
  input  logic [7:0]                        pass_count_i,
  input  tte_pkg::stat_t                    stat_i,
  output tte_pkg::ctrl_t                    ctrl_o,
  output logic [2*$clog2(GRID_MAX)-1:0]     addr_o
);

  localparam int CW = $clog2(GRID_MAX);
  localparam int NW = $clog2(GRID_MAX + 1);
  localparam int AB = 2 * CW;

  localparam logic [2:0] SCAN_HERE     = 3'd0;
  localparam logic [2:0] SCAN_TAKE     = 3'd1;
  localparam logic [2:0] SCAN_FIRST_NB = 3'd2;
  localparam logic [2:0] SCAN_LAST     = 3'd5;

  tte_pkg::state_e state_q, state_d;
  tte_pkg::dir_e   dir_q, dir_d;
  logic [CW-1:0]   x_q, x_d, z_q, z_d;
  logic [2:0]      k_q, k_d;
  logic [7:0]      p_q, p_d;
  logic [NW-1:0]   n_q, n_d;
  logic [AB-1:0]   clr_q, clr_d;

  logic          accept;
  logic [NW-1:0] n_clip, x_ext, z_ext;
  logic          x_int_last, z_int_last, x_edge_last, z_edge_last;
  logic          cell_last, apply_last, p_last;
  logic [CW-1:0] x_nxt_int, z_nxt_int, x_nxt_all, z_nxt_all;
  logic [2:0]    k_m1, k_nb;

  function automatic logic [AB-1:0] nb_addr(input logic [CW-1:0] x, input logic [CW-1:0] z,
                                            input tte_pkg::dir_e d);
    logic [AB-1:0] a;
    case (d)
      tte_pkg::DIR_XP: a = {z, x + CW'(1)};
      tte_pkg::DIR_XN: a = {z, x - CW'(1)};
      tte_pkg::DIR_ZP: a = {z + CW'(1), x};
      tte_pkg::DIR_ZN: a = {z - CW'(1), x};
      default:         a = {z, x};
    endcase
    return a;
  endfunction

  assign accept = stat_i.in_valid && stat_i.out_free && (state_q == tte_pkg::ST_IDLE);
  assign n_clip = (32'(grid_size_i) > GRID_MAX) ? NW'(GRID_MAX) : NW'(grid_size_i);

  assign x_ext       = NW'(x_q);
  assign z_ext       = NW'(z_q);
  assign x_int_last  = (x_ext == n_q - NW'(2));
  assign z_int_last  = (z_ext == n_q - NW'(2));
  assign x_edge_last = (x_ext == n_q - NW'(1));
  assign z_edge_last = (z_ext == n_q - NW'(1));
  assign cell_last   = x_int_last && z_int_last;
  assign apply_last  = x_edge_last && z_edge_last;
  assign p_last      = ((p_q + 8'd1) == pass_count_i);

  assign x_nxt_int = cell_last ? '0 : (x_int_last ? CW'(1) : x_q + CW'(1));
  assign z_nxt_int = cell_last ? '0 : (x_int_last ? z_q + CW'(1) : z_q);
  assign x_nxt_all = apply_last ? CW'(1) : (x_edge_last ? '0 : x_q + CW'(1));
  assign z_nxt_all = apply_last ? CW'(1) : (x_edge_last ? z_q + CW'(1) : z_q);

  assign k_m1 = k_q - 3'd1;
  assign k_nb = k_q - SCAN_FIRST_NB;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tte_pkg::ST_CLEAR: begin
        if (&clr_q) state_d = tte_pkg::ST_IDLE;
      end
      tte_pkg::ST_IDLE: begin
        if (accept) begin
          case (stat_i.op)
            tte_pkg::OP_READ: state_d = tte_pkg::ST_READ;
            tte_pkg::OP_RUN:  state_d = tte_pkg::ST_START;
            default:          state_d = tte_pkg::ST_IDLE;
          endcase
        end
      end
      tte_pkg::ST_READ: state_d = tte_pkg::ST_IDLE;
      tte_pkg::ST_START: begin
        if (n_q < NW'(3) || pass_count_i == 8'd0) state_d = tte_pkg::ST_DONE;
        else state_d = tte_pkg::ST_SCAN;
      end
      tte_pkg::ST_SCAN: begin
        if (k_q == SCAN_LAST) state_d = tte_pkg::ST_DROP;
      end
      tte_pkg::ST_DROP: state_d = tte_pkg::ST_TALUS;
      tte_pkg::ST_TALUS: begin
        if (stat_i.excess_pos) state_d = tte_pkg::ST_MUL;
        else if (cell_last) state_d = tte_pkg::ST_APPLY_RD;
        else state_d = tte_pkg::ST_SCAN;
      end
      tte_pkg::ST_MUL:     state_d = tte_pkg::ST_DHERE;
      tte_pkg::ST_DHERE:   state_d = tte_pkg::ST_DLOW_RD;
      tte_pkg::ST_DLOW_RD: state_d = tte_pkg::ST_DLOW_WR;
      tte_pkg::ST_DLOW_WR: begin
        if (cell_last) state_d = tte_pkg::ST_APPLY_RD;
        else state_d = tte_pkg::ST_SCAN;
      end
      tte_pkg::ST_APPLY_RD: state_d = tte_pkg::ST_APPLY_WR;
      tte_pkg::ST_APPLY_WR: begin
        if (apply_last) begin
          if (p_last) state_d = tte_pkg::ST_DONE;
          else state_d = tte_pkg::ST_SCAN;
        end else begin
          state_d = tte_pkg::ST_APPLY_RD;
        end
      end
      tte_pkg::ST_DONE: state_d = tte_pkg::ST_IDLE;
      default:          state_d = tte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.alu_sel = tte_pkg::ALU_PASS_IN;
    ctrl_o.out_op  = tte_pkg::OP_WRITE;
    addr_o         = {z_q, x_q};
    x_d            = x_q;
    z_d            = z_q;
    k_d            = k_q;
    p_d            = p_q;
    n_d            = n_q;
    dir_d          = dir_q;
    clr_d          = clr_q;
    case (state_q)
      tte_pkg::ST_CLEAR: begin
        ctrl_o.d_wr   = 1'b1;
        ctrl_o.d_zero = 1'b1;
        addr_o        = clr_q;
        clr_d         = clr_q + AB'(1);
      end
      tte_pkg::ST_IDLE: begin
        ctrl_o.in_ready = stat_i.out_free;
        ctrl_o.host     = 1'b1;
        if (accept) begin
          case (stat_i.op)
            tte_pkg::OP_WRITE: begin
              ctrl_o.h_wr   = 1'b1;
              ctrl_o.out_ld = 1'b1;
              ctrl_o.out_op = tte_pkg::OP_WRITE;
            end
            tte_pkg::OP_READ: ctrl_o.h_rd = 1'b1;
            tte_pkg::OP_RUN:  n_d = n_clip;
            default:          n_d = n_q;
          endcase
        end
      end
      tte_pkg::ST_READ: begin
        ctrl_o.alu_sel = tte_pkg::ALU_PASS_RD;
        ctrl_o.out_ld  = 1'b1;
        ctrl_o.out_op  = tte_pkg::OP_READ;
      end
      tte_pkg::ST_START: begin
        x_d = CW'(1);
        z_d = CW'(1);
        k_d = SCAN_HERE;
        p_d = 8'd0;
      end
      tte_pkg::ST_SCAN: begin
        k_d = (k_q == SCAN_LAST) ? SCAN_HERE : k_q + 3'd1;
        if (k_q == SCAN_HERE) begin
          ctrl_o.h_rd = 1'b1;
        end else if (k_q < SCAN_LAST) begin
          ctrl_o.h_rd = 1'b1;
          addr_o      = nb_addr(x_q, z_q, tte_pkg::dir_e'(k_m1[1:0]));
        end
        if (k_q == SCAN_TAKE) ctrl_o.ld_here = 1'b1;
        if (k_q >= SCAN_FIRST_NB) begin
          ctrl_o.ld_nb   = 1'b1;
          ctrl_o.alu_sel = tte_pkg::ALU_CMP;
          if (stat_i.nb_lower) dir_d = tte_pkg::dir_e'(k_nb[1:0]);
        end
      end
      tte_pkg::ST_DROP: begin
        ctrl_o.alu_sel = tte_pkg::ALU_DROP;
        ctrl_o.ld_drop = 1'b1;
      end
      tte_pkg::ST_TALUS: begin
        ctrl_o.alu_sel = tte_pkg::ALU_TALUS;
        if (stat_i.excess_pos) begin
          ctrl_o.ld_excess = 1'b1;
        end else begin
          x_d = x_nxt_int;
          z_d = z_nxt_int;
        end
      end
      tte_pkg::ST_MUL: begin
        ctrl_o.ld_prod = 1'b1;
        ctrl_o.d_rd    = 1'b1;
      end
      tte_pkg::ST_DHERE: begin
        ctrl_o.alu_sel = tte_pkg::ALU_DSUB;
        ctrl_o.d_wr    = 1'b1;
      end
      tte_pkg::ST_DLOW_RD: begin
        ctrl_o.d_rd = 1'b1;
        addr_o      = nb_addr(x_q, z_q, dir_q);
      end
      tte_pkg::ST_DLOW_WR: begin
        ctrl_o.alu_sel = tte_pkg::ALU_DADD;
        ctrl_o.d_wr    = 1'b1;
        addr_o         = nb_addr(x_q, z_q, dir_q);
        x_d            = x_nxt_int;
        z_d            = z_nxt_int;
      end
      tte_pkg::ST_APPLY_RD: begin
        ctrl_o.h_rd = 1'b1;
        ctrl_o.d_rd = 1'b1;
      end
      tte_pkg::ST_APPLY_WR: begin
        ctrl_o.alu_sel = tte_pkg::ALU_APPLY;
        ctrl_o.h_wr    = 1'b1;
        ctrl_o.d_wr    = 1'b1;
        ctrl_o.d_zero  = 1'b1;
        x_d            = x_nxt_all;
        z_d            = z_nxt_all;
        if (apply_last) p_d = p_q + 8'd1;
      end
      tte_pkg::ST_DONE: begin
        ctrl_o.out_ld = 1'b1;
        ctrl_o.out_op = tte_pkg::OP_RUN;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tte_pkg::ST_CLEAR;
      dir_q   <= tte_pkg::DIR_XP;
      x_q     <= '0;
      z_q     <= '0;
      k_q     <= SCAN_HERE;
      p_q     <= 8'd0;
      n_q     <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
      x_q     <= x_d;
      z_q     <= z_d;
      k_q     <= k_d;
      p_q     <= p_d;
      n_q     <= n_d;
      clr_q   <= clr_d;
    end
  end

endmodule

### hw/rtl/thermal_talus_erosion.sv
// channel    side  beat payload
// item_i     in    operation, column, row, write_height
// result_o   out   read_height, done_operation
// cfg_*      in    write enable, register index, data (no handshake)
//
// Write: taken and answered from IDLE; read: via ST_READ (registered store read).
// Run: a pass scans C = (n-2)^2 interior cells, then adds deltas to all n * n cells,
//   serially (single-port height and delta stores, one shared adder).
// After reset every entry of the delta store is swept to zero, with item_i.ready low.
// A waiting result holds in the output register; a new beat is taken when it drains.

`include "thermal_talus_erosion_assert.svh"

module thermal_talus_erosion #(
  parameter int GRID_MAX    = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [tte_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  tte_in_if.sink                           item_i,
  tte_out_if.source                        result_o
);

  localparam int CW    = $clog2(GRID_MAX);
  localparam int AB    = 2 * CW;
  localparam int DEPTH = 1 << AB;
  localparam int HB    = HEIGHT_BITS;
  localparam int DW    = HB + 3;
  localparam int AW    = (HB + 4 > 17) ? HB + 4 : 17;
  localparam int MW    = HB + 1;
  localparam int PW    = MW + tte_pkg::MOVE_SHIFT;

  logic [6:0]  grid_size_q;
  logic [14:0] talus_q;
  logic [8:0]  rate_q;
  logic [7:0]  pass_q;

  tte_pkg::ctrl_t ctrl;
  tte_pkg::stat_t stat;
  logic [AB-1:0]  seq_addr, host_addr, h_addr;
  logic           in_store, in_store_q, h_we;

  logic [HB-1:0] hmem [DEPTH];
  logic [DW-1:0] dmem [DEPTH];
  logic [HB-1:0] hrd_q;
  logic [DW-1:0] drd_q, d_wdata;

  logic [HB-1:0] here_q, lowest_q;
  logic [MW-1:0] drop_q, excess_q, move;
  logic [PW-1:0] prod_q;
  logic [8:0]    rate_eff;

  logic [AW-1:0] op_a, op_b, alu_sum;
  logic          alu_sub, alu_neg;
  logic [HB-1:0] alu_sat_h;
  logic [15:0]   alu_sat16;

  logic               out_valid_q;
  logic signed [15:0] out_height_q;
  logic [1:0]         out_op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= tte_pkg::GRID_SIZE_RST;
      talus_q     <= tte_pkg::TALUS_RST;
      rate_q      <= tte_pkg::RATE_RST;
      pass_q      <= tte_pkg::PASS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tte_pkg::CFG_GRID_SIZE:  grid_size_q <= cfg_data_i[6:0];
        tte_pkg::CFG_TALUS:      talus_q     <= cfg_data_i[14:0];
        tte_pkg::CFG_SLUMP_RATE: rate_q      <= cfg_data_i[8:0];
        tte_pkg::CFG_PASS_COUNT: pass_q      <= cfg_data_i[7:0];
        default:                 pass_q      <= pass_q;
      endcase
    end
  end

  assign rate_eff = (rate_q > tte_pkg::RATE_ONE) ? tte_pkg::RATE_ONE : rate_q;

  assign stat.in_valid   = item_i.valid;
  assign stat.op         = item_i.operation;
  assign stat.out_free   = !out_valid_q || result_o.ready;
  assign stat.nb_lower   = alu_neg;
  assign stat.excess_pos = !alu_neg && (|alu_sum);

  tte_seq #(
    .GRID_MAX(GRID_MAX)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grid_size_i  (grid_size_q),
    .pass_count_i (pass_q),
    .stat_i       (stat),
    .ctrl_o       (ctrl),
    .addr_o       (seq_addr)
  );

  assign in_store  = (32'(item_i.column) < GRID_MAX) && (32'(item_i.row) < GRID_MAX);
  assign host_addr = {CW'(item_i.row), CW'(item_i.column)};
  assign h_addr    = ctrl.host ? host_addr : seq_addr;
  assign h_we      = ctrl.h_wr && (!ctrl.host || in_store);
  assign d_wdata   = ctrl.d_zero ? '0 : alu_sum[DW-1:0];

  always_ff @(posedge clk_i) begin
    if (h_we) hmem[h_addr] <= alu_sat_h;
    if (ctrl.h_rd) hrd_q <= hmem[h_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.d_wr) dmem[seq_addr] <= d_wdata;
    if (ctrl.d_rd) drd_q <= dmem[seq_addr];
  end

  assign move = prod_q[PW-1:tte_pkg::MOVE_SHIFT];

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    alu_sub = 1'b0;
    case (ctrl.alu_sel)
      tte_pkg::ALU_PASS_IN: begin
        op_a = {{(AW-16){item_i.write_height[15]}}, item_i.write_height};
      end
      tte_pkg::ALU_PASS_RD: begin
        op_a = {{(AW-HB){hrd_q[HB-1]}}, hrd_q};
      end
      tte_pkg::ALU_CMP: begin
        op_a    = {{(AW-HB){hrd_q[HB-1]}}, hrd_q};
        op_b    = {{(AW-HB){lowest_q[HB-1]}}, lowest_q};
        alu_sub = 1'b1;
      end
      tte_pkg::ALU_DROP: begin
        op_a    = {{(AW-HB){here_q[HB-1]}}, here_q};
        op_b    = {{(AW-HB){lowest_q[HB-1]}}, lowest_q};
        alu_sub = 1'b1;
      end
      tte_pkg::ALU_TALUS: begin
        op_a    = {{(AW-MW){1'b0}}, drop_q};
        op_b    = {{(AW-15){1'b0}}, talus_q};
        alu_sub = 1'b1;
      end
      tte_pkg::ALU_DSUB: begin
        op_a    = {{(AW-DW){drd_q[DW-1]}}, drd_q};
        op_b    = {{(AW-MW){1'b0}}, move};
        alu_sub = 1'b1;
      end
      tte_pkg::ALU_DADD: begin
        op_a = {{(AW-DW){drd_q[DW-1]}}, drd_q};
        op_b = {{(AW-MW){1'b0}}, move};
      end
      tte_pkg::ALU_APPLY: begin
        op_a = {{(AW-HB){hrd_q[HB-1]}}, hrd_q};
        op_b = {{(AW-DW){drd_q[DW-1]}}, drd_q};
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  tte_alu #(
    .HEIGHT_BITS(HB),
    .AW         (AW)
  ) u_alu (
    .a_i     (op_a),
    .b_i     (op_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .neg_o   (alu_neg),
    .sat_h_o (alu_sat_h),
    .sat16_o (alu_sat16)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_here) here_q <= hrd_q;
    if (ctrl.ld_here || (ctrl.ld_nb && alu_neg)) lowest_q <= hrd_q;
    if (ctrl.ld_drop) drop_q <= alu_sum[MW-1:0];
    if (ctrl.ld_excess) excess_q <= alu_sum[MW-1:0];
    if (ctrl.ld_prod) prod_q <= PW'(excess_q) * PW'(rate_eff);
    if (item_i.valid && item_i.ready) in_store_q <= in_store;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_ld) begin
      out_op_q     <= ctrl.out_op;
      out_height_q <= (ctrl.out_op == 2'(tte_pkg::OP_READ) && in_store_q) ? alu_sat16 : '0;
    end
  end

  assign item_i.ready            = ctrl.in_ready;
  assign result_o.valid          = out_valid_q;
  assign result_o.read_height    = out_height_q;
  assign result_o.done_operation = out_op_q;

  `TTE_ASSERT(a_out_no_overwrite, ctrl.out_ld |-> (!out_valid_q || result_o.ready), "result beat overwritten")
  `TTE_ASSERT(a_single_port, !(ctrl.h_rd && ctrl.h_wr) && !(ctrl.d_rd && ctrl.d_wr), "store port conflict")
  `TTE_ASSERT_NEXT(a_write_result, item_i.valid && item_i.ready && item_i.operation == 2'(tte_pkg::OP_WRITE), out_valid_q, "write beat gave no result")
  `TTE_ASSERT(a_prod_after_excess, ctrl.ld_prod |-> $past(ctrl.ld_excess), "product without excess")

endmodule

### test/testbench.sv
module testbench;
  import tte_pkg::*;

  localparam int GRID_MAX = 64;
  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int FILL_SPAN = 20;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES = 30;
  localparam int PHASE_ITEMS = 30;
  localparam int PRINT_CAP = 50;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [15:0] height;
    logic [1:0]  op;
  } completion_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_GRID_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic take_result = 1'b0;

  int src_idle_pct = 10;
  int sink_idle_pct = 82;
  int errors = 0;
  int cycle_count = 0;

  logic [6:0]  grid_size_reg = GRID_SIZE_RST;
  logic [14:0] talus_reg = TALUS_RST;
  logic [8:0]  rate_reg = RATE_RST;
  logic [7:0]  passes_reg = PASS_RST;

  logic signed [15:0] height_mirror [CELLS];
  int delta_mirror [CELLS];
  completion_t completions_due [$];
  completion_t due_now;

  tte_in_if item_if ();
  tte_out_if result_if ();

  assign result_if.ready = take_result;

  thermal_talus_erosion dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    take_result <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    if (errors < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    end
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (completions_due.size() == 0) begin
        report_mismatch("result beat with nothing due, op", result_if.done_operation, 0);
      end else begin
        due_now = completions_due.pop_front();
        if (result_if.done_operation !== due_now.op) begin
          report_mismatch("done_operation", result_if.done_operation, due_now.op);
        end
        if (result_if.read_height !== due_now.height) begin
          report_mismatch("read_height", $signed(result_if.read_height),
                          $signed(due_now.height));
        end
      end
    end
  end

  function automatic logic signed [15:0] clamp_height(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // all moves of a pass come from the heights at the start of the pass
  function automatic void erode_pass(int n);
    int x, z, k, at, nb, here, lowest, low_at, mv, rate;
    rate = (rate_reg > RATE_ONE) ? int'(RATE_ONE) : int'(rate_reg);
    foreach (delta_mirror[i]) delta_mirror[i] = 0;
    for (z = 1; z < n - 1; z++) begin
      for (x = 1; x < n - 1; x++) begin
        at = z * GRID_MAX + x;
        here = height_mirror[at];
        lowest = here;
        low_at = at;
        for (k = 0; k < 4; k++) begin
          case (dir_e'(k))
            DIR_XP: nb = at + 1;
            DIR_XN: nb = at - 1;
            DIR_ZP: nb = at + GRID_MAX;
            default: nb = at - GRID_MAX;
          endcase
          if (height_mirror[nb] < lowest) begin
            lowest = height_mirror[nb];
            low_at = nb;
          end
        end
        if (here - lowest > int'(talus_reg)) begin
          mv = ((here - lowest - int'(talus_reg)) * rate) >>> MOVE_SHIFT;
          delta_mirror[at] -= mv;
          delta_mirror[low_at] += mv;
        end
      end
    end
    for (z = 0; z < n; z++) begin
      for (x = 0; x < n; x++) begin
        at = z * GRID_MAX + x;
        height_mirror[at] = clamp_height(height_mirror[at] + delta_mirror[at]);
      end
    end
  endfunction

  function automatic void grid_step(logic [1:0] op, logic [5:0] col, logic [5:0] row,
                                    logic signed [15:0] wh);
    completion_t c;
    int n;
    int at;
    at = int'(row) * GRID_MAX + int'(col);
    c.op = op;
    c.height = '0;
    case (op)
      OP_WRITE: height_mirror[at] = wh;
      OP_READ: c.height = height_mirror[at];
      OP_RUN: begin
        n = (grid_size_reg > GRID_MAX) ? GRID_MAX : int'(grid_size_reg);
        if (n >= 3) repeat (passes_reg) erode_pass(n);
      end
      default: return;
    endcase
    completions_due = {completions_due, c};
  endfunction

  task automatic send_item(logic [1:0] op, logic [5:0] col, logic [5:0] row,
                           logic signed [15:0] wh);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.operation <= op;
    item_if.column <= col;
    item_if.row <= row;
    item_if.write_height <= wh;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    grid_step(op, col, row, wh);
  endtask

  task automatic write_cell(int col, int row, logic [15:0] h);
    send_item(OP_WRITE, 6'(col), 6'(row), h);
  endtask

  task automatic read_cell(int col, int row);
    send_item(OP_READ, 6'(col), 6'(row), 16'($urandom));
  endtask

  task automatic run_passes();
    send_item(OP_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    while (completions_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // bits above each register's width carry junk
  task automatic set_config(int gs, int tal, int rate, int passes);
    logic [1:0] idx [4];
    int value [4];
    int width [4];
    int i;
    idx = '{CFG_GRID_SIZE, CFG_TALUS, CFG_SLUMP_RATE, CFG_PASS_COUNT};
    value = '{gs, tal, rate, passes};
    width = '{7, 15, 9, 8};
    settle();
    for (i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_data <= 15'(value[i]) | (15'($urandom) << width[i]);
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    grid_size_reg = 7'(gs);
    talus_reg = 15'(tal);
    rate_reg = 9'(rate);
    passes_reg = 8'(passes);
  endtask

  task automatic set_grid_size(int gs);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_GRID_SIZE;
    cfg_data <= 15'(gs);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    grid_size_reg = 7'(gs);
  endtask

  function automatic logic [15:0] rand_height();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1, 2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 4095) - 2048);
    endcase
  endfunction

  function automatic int pick_coord(int span);
    if ($urandom_range(0, 99) < 75) return $urandom_range(0, span - 1);
    return $urandom_range(0, FILL_SPAN - 1);
  endfunction

  task automatic test_fill_grid();
    int r, c;
    for (r = 0; r < FILL_SPAN; r++) begin
      for (c = 0; c < FILL_SPAN; c++) write_cell(c, r, rand_height());
    end
  endtask

  task automatic test_corners();
    write_cell(0, 0, 16'h7fff);
    write_cell(63, 63, 16'h8000);
    write_cell(63, 0, rand_height());
    write_cell(0, 63, rand_height());
    read_cell(0, 0);
    read_cell(63, 63);
    read_cell(63, 0);
    read_cell(0, 63);
  endtask

  // reset talus, rate and pass count over the filled corner
  task automatic test_reset_run();
    set_grid_size(FILL_SPAN);
    run_passes();
    read_cell(10, 10);
    read_cell(1, 1);
  endtask

  task automatic test_small_grid();
    set_config(2, 0, 256, 3);
    run_passes();
    set_config(0, 0, 256, 3);
    run_passes();
    read_cell(1, 1);
  endtask

  task automatic test_saturation();
    set_config(3, 0, 511, 255);
    write_cell(1, 1, 16'h7fff);
    write_cell(2, 1, 16'h8000);
    run_passes();
    read_cell(1, 1);
    read_cell(2, 1);
    read_cell(1, 0);
  endtask

  task automatic test_zero_rate_and_unused_op();
    set_config(5, 0, 0, 2);
    run_passes();
    send_item(OP_NONE, 6'($urandom), 6'($urandom), 16'($urandom));
    read_cell(2, 2);
  endtask

  task automatic test_random_phases();
    int phase, count, pick, span, gs, passes, tal;
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES / 3) begin
        src_idle_pct = 82;
        sink_idle_pct = 10;
      end
      if (phase == 2 * PHASES / 3) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        gs = $urandom_range(0, 2);
        passes = $urandom_range(0, 255);
      end else if (pick == 1) begin
        gs = 3;
        passes = $urandom_range(128, 255);
      end else if (pick == 2) begin
        gs = $urandom_range(10, 20);
        passes = $urandom_range(0, 1);
      end else begin
        gs = $urandom_range(3, 9);
        passes = $urandom_range(0, 4);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) tal = 0;
      else if (pick == 1) tal = 32767;
      else if (pick < 4) tal = $urandom_range(0, 32767);
      else tal = $urandom_range(0, 1023);
      set_config(gs, tal, $urandom_range(0, 511), passes);
      span = (gs < 3) ? 3 : gs;
      count = 0;
      while (count < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_item(OP_NONE, 6'($urandom), 6'($urandom), 16'($urandom));
        end else begin
          if (pick < 42) write_cell(pick_coord(span), pick_coord(span), rand_height());
          else if (pick < 92) read_cell(pick_coord(span), pick_coord(span));
          else run_passes();
          count++;
        end
      end
    end
  endtask

  initial begin
    item_if.valid <= 1'b0;
    item_if.operation <= OP_WRITE;
    item_if.column <= '0;
    item_if.row <= '0;
    item_if.write_height <= '0;
    foreach (height_mirror[i]) height_mirror[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_fill_grid();
    test_corners();
    test_reset_run();
    test_small_grid();
    test_saturation();
    test_zero_rate_and_unused_op();
    test_random_phases();
    settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tte_pkg.sv
hw/rtl/tte_in_if.sv
hw/rtl/tte_out_if.sv
hw/rtl/tte_alu.sv
hw/rtl/tte_seq.sv
hw/rtl/thermal_talus_erosion.sv
test/testbench.sv
